// ===== rtl/base64_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Base64 decoder assertion macros
// Shared property forms for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_UNIT_DEFINES_SVH
`define BASE64_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define B64D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("base64 decoder check failed");

// Next-cycle implication, checked only outside reset.
`define B64D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("base64 decoder check failed");

`endif

// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    // Characters of the RFC 4648 alphabet that bound the ranges.
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;

    localparam logic [7:0] OFS_LOWER   = 8'd26;
    localparam logic [7:0] OFS_DIGIT   = 8'd52;
    localparam logic [5:0] VAL_PLUS    = 6'd62;
    localparam logic [5:0] VAL_SLASH   = 6'd63;

    // Result buffer geometry; a request may push up to three results.
    localparam int RBUF_DEPTH = 8;
    localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
    localparam int MAX_PUSH   = 3;

    // Bit positions inside the output tuser.
    localparam int TUSER_VALID = 0;
    localparam int TUSER_EARLY = 1;

    typedef struct packed {
        logic [5:0] value;
        logic       ok;
    } t_sextet;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       early;
    } t_result;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [MAX_PUSH-1:0]     res;
    } t_push;

    typedef struct packed {
        logic [1:0]  group_count;
        logic [17:0] acc;
        logic        halted;
    } t_dec_state;

endpackage

`default_nettype wire

// ===== rtl/b64d_sextet.sv =====
// ----------------------------------------------------------------------------
// Base64 character classifier
// Maps one raw byte to its six-bit value and flags non-alphabet bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_sextet (
    input  wire logic [7:0]       i_char,
    output b64d_pkg::t_sextet     o_sextet
);
    import b64d_pkg::*;

    logic [7:0] w_val;

    always_comb begin
        w_val       = 8'd0;
        o_sextet.ok = 1'b1;
        if (i_char >= CHR_UPPER_A && i_char <= CHR_UPPER_Z) begin
            w_val = i_char - CHR_UPPER_A;
        end else if (i_char >= CHR_LOWER_A && i_char <= CHR_LOWER_Z) begin
            w_val = i_char - CHR_LOWER_A + OFS_LOWER;
        end else if (i_char >= CHR_DIGIT_0 && i_char <= CHR_DIGIT_9) begin
            w_val = i_char - CHR_DIGIT_0 + OFS_DIGIT;
        end else if (i_char == CHR_PLUS) begin
            w_val = {2'b00, VAL_PLUS};
        end else if (i_char == CHR_SLASH) begin
            w_val = {2'b00, VAL_SLASH};
        end else begin
            o_sextet.ok = 1'b0;
        end
        o_sextet.value = w_val[5:0];
    end

endmodule

`default_nettype wire

// ===== rtl/b64d_decode.sv =====
// ----------------------------------------------------------------------------
// Base64 group decoder
// Holds the partial group and halt flag, and forms the results of a request.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_char,
    input  wire logic               i_end,
    output b64d_pkg::t_push         o_push,
    output b64d_pkg::t_dec_state    o_state
);
    import b64d_pkg::*;

    t_sextet             w_sx;
    logic [1:0]          r_gc;
    logic [1:0]          n_gc;
    logic [17:0]         r_acc;
    logic [17:0]         n_acc;
    logic                r_halt;
    logic                n_halt;
    logic [23:0]         w_full;
    logic [2:0][7:0]     w_byte;
    logic [1:0]          w_nb;

    b64d_sextet u_sextet (
        .i_char   (i_char),
        .o_sextet (w_sx)
    );

    always_comb begin
        n_gc   = r_gc;
        n_acc  = r_acc;
        n_halt = r_halt;
        w_full = 24'd0;
        w_byte = '0;
        w_nb   = 2'd0;

        if (!r_halt) begin
            if (!w_sx.ok) begin
                n_halt = 1'b1;
            end else if (r_gc == 2'd3) begin
                w_full    = {r_acc, w_sx.value};
                w_byte[0] = w_full[23:16];
                w_byte[1] = w_full[15:8];
                w_byte[2] = w_full[7:0];
                w_nb      = 2'd3;
                n_gc      = 2'd0;
                n_acc     = 18'd0;
            end else begin
                n_acc = {r_acc[11:0], w_sx.value};
                n_gc  = r_gc + 2'd1;
            end
        end

        // A full group always leaves the count at zero, so the flush never
        // adds to three bytes already formed.
        if (i_end) begin
            case (n_gc)
                2'd2: begin
                    w_byte[0] = n_acc[11:4];
                    w_nb      = 2'd1;
                end
                2'd3: begin
                    w_byte[0] = n_acc[17:10];
                    w_byte[1] = n_acc[9:2];
                    w_nb      = 2'd2;
                end
                default: begin
                end
            endcase
        end

        for (int k = 0; k < MAX_PUSH; k++) begin
            o_push.res[k].data  = w_byte[k];
            o_push.res[k].valid = (2'(k) < w_nb);
            o_push.res[k].last  = i_end && (2'(k + 1) == w_nb);
            o_push.res[k].early = i_end && (2'(k + 1) == w_nb) && n_halt;
        end
        o_push.cnt = w_nb;

        // End of message with nothing to flush gives one data-less result.
        if (i_end && w_nb == 2'd0) begin
            o_push.res[0].data  = 8'd0;
            o_push.res[0].valid = 1'b0;
            o_push.res[0].last  = 1'b1;
            o_push.res[0].early = n_halt;
            o_push.cnt          = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc   <= 2'd0;
            r_acc  <= 18'd0;
            r_halt <= 1'b0;
        end else if (i_accept) begin
            if (i_end) begin
                r_gc   <= 2'd0;
                r_acc  <= 18'd0;
                r_halt <= 1'b0;
            end else begin
                r_gc   <= n_gc;
                r_acc  <= n_acc;
                r_halt <= n_halt;
            end
        end
    end

    assign o_state.group_count = r_gc;
    assign o_state.acc         = r_acc;
    assign o_state.halted      = r_halt;

endmodule

`default_nettype wire

// ===== rtl/b64d_rbuf.sv =====
// ----------------------------------------------------------------------------
// Base64 result buffer
// Small queue that takes up to three results at once and hands out one a cycle while popped.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_rbuf (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push_en,
    input  wire b64d_pkg::t_push            i_push,
    input  wire logic                       i_pop,
    output b64d_pkg::t_result               o_head,
    output logic                            o_nonempty,
    output logic                            o_room,
    output logic [b64d_pkg::RBUF_AW:0]      o_fill
);
    import b64d_pkg::*;

    t_result                r_mem [RBUF_DEPTH];
    logic [RBUF_AW-1:0]     r_wr;
    logic [RBUF_AW-1:0]     r_rd;
    logic [RBUF_AW:0]       r_fill;
    logic [1:0]             w_push_cnt;

    assign w_push_cnt = i_push_en ? i_push.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < w_push_cnt) begin
                r_mem[RBUF_AW'(r_wr + RBUF_AW'(k))] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= r_wr + RBUF_AW'(w_push_cnt);
            r_rd   <= r_rd + RBUF_AW'(i_pop);
            r_fill <= r_fill + (RBUF_AW+1)'(w_push_cnt) - (RBUF_AW+1)'(i_pop);
        end
    end

    assign o_head     = r_mem[r_rd];
    assign o_nonempty = (r_fill != '0);
    // Room for a whole request's worth of results, regardless of the pop.
    assign o_room     = (r_fill <= (RBUF_AW+1)'(RBUF_DEPTH - MAX_PUSH));
    assign o_fill     = r_fill;

endmodule

`default_nettype wire

// ===== rtl/base64_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder unit
// Streaming RFC 4648 base64 decoder, one character per request.
// ----------------------------------------------------------------------------
// The slave channel takes one character per request in s_axis_tdata, with
// s_axis_tlast marking the final character of a message. The master channel
// gives one result per request: the decoded byte in m_axis_tdata, tuser bit 0
// set when the byte is real data, tuser bit 1 set on the final result when
// '=' or a non-alphabet byte stopped decoding, and tlast on the final result.
// A character is decoded in the cycle it is accepted and its results, up to
// three, are written into an eight-entry result queue, from which the master
// side offers them in order. The slave side takes a character every cycle
// while the queue has room for three more results, so it sustains one
// character per cycle as long as the receiver takes one result per cycle;
// the queue drains at one result per cycle while the receiver is ready. When
// the receiver stalls, the queue fills and s_axis_tready falls once fewer
// than three entries are free; nothing is lost or dropped. Reset clears the
// partial group, the halt flag and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_decoder_unit_defines.svh"

module base64_decoder_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire logic [7:0]     i_s_axis_tdata,     // [7:0] in_char
    input  wire logic           i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,     // [7:0] out_byte
    output logic [1:0]          o_m_axis_tuser,     // [0] out_valid, [1] halted_early
    output logic                o_m_axis_tlast
);
    import b64d_pkg::*;

    logic               w_in_acc;
    logic               w_out_acc;
    t_push              w_push;
    t_dec_state         w_state;
    t_result            w_head;
    logic               w_room;
    logic [RBUF_AW:0]   w_fill;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    b64d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_char   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .o_push   (w_push),
        .o_state  (w_state)
    );

    b64d_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_en  (w_in_acc),
        .i_push     (w_push),
        .i_pop      (w_out_acc),
        .o_head     (w_head),
        .o_nonempty (o_m_axis_tvalid),
        .o_room     (w_room),
        .o_fill     (w_fill)
    );

    assign o_s_axis_tready             = w_room;
    assign o_m_axis_tdata              = w_head.data;
    assign o_m_axis_tuser[TUSER_VALID] = w_head.valid;
    assign o_m_axis_tuser[TUSER_EARLY] = w_head.early;
    assign o_m_axis_tlast              = w_head.last;

    // The queue never holds more results than it has entries.
    `B64D_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, w_fill <= (RBUF_AW+1)'(RBUF_DEPTH))

    // The end of a message leaves the decoder clean for the next one.
    `B64D_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, w_in_acc && i_s_axis_tlast,
        w_state.group_count == 2'd0 && w_state.acc == 18'd0 && !w_state.halted)

    // The halt status is only ever reported on the final result.
    `B64D_ASSERT_IMP(a_early_last, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[TUSER_EARLY], o_m_axis_tlast)

endmodule

`default_nettype wire

// ===== dv/b64d_decode_checker.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder result checker
// Follows every character request into the decoder, works out the bytes it
// should give back and compares each result request with the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module b64d_decode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,     // [7:0] in_char
    input  logic       i_s_axis_tlast,
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,     // [7:0] out_byte
    input  logic [1:0] i_m_axis_tuser,     // [0] out_valid, [1] halted_early
    input  logic       i_m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);
    import b64d_pkg::*;

    t_result     expected_bytes[$];
    logic [1:0]  grp_cnt;
    logic [17:0] held_sextets;
    logic        halt_seen;
    t_result     seen;
    t_result     want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        grp_cnt      = '0;
        held_sextets = '0;
        halt_seen    = 1'b0;
    end

    function automatic t_sextet char_to_sextet(input logic [7:0] ch);
        t_sextet    sx;
        logic [7:0] v8;
        sx.ok = 1'b1;
        v8    = '0;
        if (ch >= CHR_UPPER_A && ch <= CHR_UPPER_Z) begin
            v8 = ch - CHR_UPPER_A;
        end else if (ch >= CHR_LOWER_A && ch <= CHR_LOWER_Z) begin
            v8 = ch - CHR_LOWER_A + OFS_LOWER;
        end else if (ch >= CHR_DIGIT_0 && ch <= CHR_DIGIT_9) begin
            v8 = ch - CHR_DIGIT_0 + OFS_DIGIT;
        end else if (ch == CHR_PLUS) begin
            v8 = {2'b00, VAL_PLUS};
        end else if (ch == CHR_SLASH) begin
            v8 = {2'b00, VAL_SLASH};
        end else begin
            sx.ok = 1'b0;
        end
        sx.value = v8[5:0];
        return sx;
    endfunction

    task automatic decode_char(input logic [7:0] ch, input logic last);
        t_sextet    sx;
        logic [23:0] full;
        logic [7:0] bytes [0:2];
        int         n;
        t_result    r;
        n = 0;
        if (!halt_seen) begin
            sx = char_to_sextet(ch);
            if (!sx.ok) begin
                halt_seen = 1'b1;
            end else if (grp_cnt == 2'd3) begin
                full         = {held_sextets, sx.value};
                bytes[0]     = full[23:16];
                bytes[1]     = full[15:8];
                bytes[2]     = full[7:0];
                n            = 3;
                grp_cnt      = '0;
                held_sextets = '0;
            end else begin
                held_sextets = {held_sextets[11:0], sx.value};
                grp_cnt      = grp_cnt + 2'd1;
            end
        end
        // A partial group is flushed even when decoding has halted.
        if (last) begin
            if (grp_cnt == 2'd2) begin
                bytes[n] = held_sextets[11:4];
                n        = n + 1;
            end else if (grp_cnt == 2'd3) begin
                bytes[n]     = held_sextets[17:10];
                bytes[n + 1] = held_sextets[9:2];
                n            = n + 2;
            end
        end
        for (int k = 0; k < n; k++) begin
            r.data  = bytes[k];
            r.valid = 1'b1;
            r.last  = last && (k == n - 1);
            r.early = r.last ? halt_seen : 1'b0;
            expected_bytes.push_back(r);
        end
        if (last) begin
            if (n == 0) begin
                r.data  = '0;
                r.valid = 1'b0;
                r.last  = 1'b1;
                r.early = halt_seen;
                expected_bytes.push_back(r);
            end
            grp_cnt      = '0;
            held_sextets = '0;
            halt_seen    = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grp_cnt      = '0;
            held_sextets = '0;
            halt_seen    = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                decode_char(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.data  = i_m_axis_tdata;
                seen.valid = i_m_axis_tuser[TUSER_VALID];
                seen.early = i_m_axis_tuser[TUSER_EARLY];
                seen.last  = i_m_axis_tlast;
                if (expected_bytes.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected result: data %02h valid %b last %b early %b",
                             $time, seen.data, seen.valid, seen.last, seen.early);
                end else begin
                    want = expected_bytes.pop_front();
                    if (seen !== want) begin
                        o_fail_count = o_fail_count + 1;
                        // Fields are listed as data, valid, last, early.
                        $display("%0t: mismatch: expected %02h %b %b %b, actual %02h %b %b %b",
                                 $time, want.data, want.valid, want.last, want.early,
                                 seen.data, seen.valid, seen.last, seen.early);
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Base64 decoder testbench
// Sends directed and random messages in bursts against a stalling receiver;
// the checker beside the decoder predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    LONG_HOLD      = 300;
    localparam int    RANDOM_ITEMS   = 445;
    localparam string B64_CHARS      =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = '0;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    int         fail_count;
    int         pending;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    int         hold_left   = 0;
    bit         hold_req    = 1'b0;
    int         rx_mode     = 0;
    int         rx_phase    = 0;
    logic [7:0] rx_mask     = '1;
    int         rx_tick     = 0;

    always #5 i_clk = ~i_clk;

    base64_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    b64d_decode_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: the stall pattern is redrawn whenever its phase counter runs out, and a long
    // hold-off is counted here once the stimulus asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (rx_phase == 0) begin
                rx_mode  = $urandom_range(0, 3);
                rx_phase = $urandom_range(16, 96);
                rx_mask  = 8'($urandom);
            end else begin
                rx_phase = rx_phase - 1;
            end
            rx_tick = rx_tick + 1;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= rx_mask[3'(rx_tick % 8)];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        burst_left = burst_left - 1;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], k == s.len() - 1);
        end
    endtask

    // Stops offering requests until every predicted result has been taken.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Mostly well-formed messages with random content, padding or stray
    // bytes at the tail; the rest is noise over the whole byte range.
    task automatic send_random_message(inout int sent);
        logic [7:0] msg[$];
        int         kind;
        int         len;
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 16);
        for (int k = 0; k < len; k++) begin
            if (kind <= 6) begin
                msg.push_back(B64_CHARS[$urandom_range(0, 63)]);
            end else begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (kind <= 6) begin
            case ($urandom_range(0, 3))
                2: begin
                    msg.push_back("=");
                    if ($urandom_range(0, 1) == 1) begin
                        msg.push_back("=");
                    end
                end
                3: begin
                    repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
        if (msg.size() == 0) begin
            msg.push_back(8'($urandom_range(0, 255)));
        end
        foreach (msg[k]) begin
            send_char(msg[k], k == msg.size() - 1);
        end
        sent = sent + msg.size();
    endtask

    initial begin
        int sent;
        bit hold_done;
        bit drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("+/0z");      // full group on the final character
        send_text("AAaAZw");    // one group, then two leftover sextets
        send_text("QU9");       // three leftover sextets
        send_text("Q");         // a single leftover sextet gives no byte
        send_text("=");         // halted with nothing to flush
        send_char("Q", 1'b0);   // a non-ASCII final character halts first
        send_char("U", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("Q", 1'b0);   // characters after the halt are ignored
        send_char("U", 1'b0);
        send_char("J", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("=", 1'b0);
        send_char("b", 1'b1);

        while (sent < RANDOM_ITEMS) begin
            if (sent >= 150 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (sent >= 300 && !drain_done) begin
                wait_drained();
                drain_done = 1'b1;
            end
            send_random_message(sent);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_sextet.sv
rtl/b64d_decode.sv
rtl/b64d_rbuf.sv
rtl/base64_decoder_unit.sv
dv/b64d_decode_checker.sv
dv/tb.sv
